// ----- hdl/aarm_pkg.sv -----
// Package for the angle-axis rotation matrix pipeline: formats, constants, CORDIC helpers.
`timescale 1ns / 1ps
package aarm_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int FRAC_BITS    = 14;
    localparam int ATAN_ENTRIES = 24;
    localparam int N_STEPS      = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int OUT_SHIFT    = 48 - FRAC_BITS;
    localparam int VLD_LAST     = N_STEPS + 4;    // valid bit of the Q48 sum stage

    localparam int IN_W    = 16;
    localparam int OUT_W   = 18;
    localparam int ANG_W   = 34;    // Q2.30 angle and CORDIC x/y
    localparam int WRAP_W  = 36;    // raw Q2.30 angle before wrapping
    localparam int SC_W    = 24;    // sin and (1 - cos) in Q20
    localparam int UU_W    = 32;    // entries of U*U, Q28
    localparam int SA_W    = SC_W + IN_W;
    localparam int OU_W    = SC_W + UU_W;
    localparam int ACC_W   = 58;    // Q48 entry sum
    localparam int N_OUT   = 9;
    localparam int IN_TDATA_W  = 4 * IN_W;
    localparam int OUT_PACK_W  = N_OUT * OUT_W;
    localparam int OUT_TDATA_W = ((OUT_PACK_W + 7) / 8) * 8;

    typedef logic signed [ANG_W-1:0]  t_ang;
    typedef logic signed [WRAP_W-1:0] t_wrap;
    typedef logic signed [IN_W-1:0]   t_axis;
    typedef logic signed [UU_W-1:0]   t_uu;
    typedef logic signed [SC_W-1:0]   t_sc;
    typedef logic signed [SA_W-1:0]   t_sa;
    typedef logic signed [OU_W-1:0]   t_ou;
    typedef logic signed [ACC_W-1:0]  t_acc;

    localparam t_wrap PI_W      = 36'sd3373259426;
    localparam t_wrap TWO_PI_W  = 36'sd6746518852;
    localparam t_ang  PI_Q30    = 34'sd3373259426;
    localparam t_ang  HALF_PI   = 34'sd1686629713;
    localparam t_ang  ONE_Q30   = 34'sd1073741824;
    localparam t_ang  GAIN_Q30  = 34'sd652032874;
    localparam t_ang  SC_ROUND  = 34'sd512;
    localparam t_acc  ONE_Q48   = t_acc'(1) <<< 48;
    localparam t_acc  OUT_HALF  = t_acc'(1) <<< (OUT_SHIFT - 1);
    localparam t_acc  OUT_MAX   = 58'sd131071;
    localparam t_acc  OUT_MIN   = -58'sd131072;

    // CORDIC working set
    typedef struct packed {
        t_ang x;
        t_ang y;
        t_ang z;
        logic flip;
    } t_rot;

    // axis and U*U = a*a' - |a|^2 I, symmetric
    typedef struct packed {
        t_axis ax;
        t_axis ay;
        t_axis az;
        t_uu   d0;
        t_uu   d1;
        t_uu   d2;
        t_uu   o01;
        t_uu   o02;
        t_uu   o12;
    } t_geo;

    function automatic t_ang atan_q30(input int idx);
        t_ang v;
        case (idx)
            0:       v = 34'sh3243F6A8;
            1:       v = 34'sh1DAC6705;
            2:       v = 34'sh0FADBAFC;
            3:       v = 34'sh07F56EA6;
            4:       v = 34'sh03FEAB76;
            5:       v = 34'sh01FFD55B;
            6:       v = 34'sh00FFFAAA;
            7:       v = 34'sh007FFF55;
            8:       v = 34'sh003FFFEA;
            9:       v = 34'sh001FFFFD;
            10:      v = 34'sh000FFFFF;
            11:      v = 34'sh0007FFFF;
            12:      v = 34'sh0003FFFF;
            13:      v = 34'sh0001FFFF;
            14:      v = 34'sh0000FFFF;
            15:      v = 34'sh00007FFF;
            16:      v = 34'sh00003FFF;
            17:      v = 34'sh00001FFF;
            18:      v = 34'sh00000FFF;
            19:      v = 34'sh000007FF;
            20:      v = 34'sh000003FF;
            21:      v = 34'sh000001FF;
            22:      v = 34'sh000000FF;
            23:      v = 34'sh0000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

    // one rotation-mode micro-rotation, floor shifts
    function automatic t_rot cordic_step(input t_rot p, input int idx);
        t_rot q;
        t_ang dx;
        t_ang dy;
        dx = p.y >>> idx;
        dy = p.x >>> idx;
        q = p;
        if (!p.z[ANG_W-1]) begin
            q.x = p.x - dx;
            q.y = p.y + dy;
            q.z = p.z - atan_q30(idx);
        end else begin
            q.x = p.x + dx;
            q.y = p.y - dy;
            q.z = p.z + atan_q30(idx);
        end
        return q;
    endfunction

    function automatic logic [OUT_W-1:0] sat_out(input t_acc a);
        t_acc v;
        v = a >>> OUT_SHIFT;
        if (v > OUT_MAX) begin
            v = OUT_MAX;
        end else if (v < OUT_MIN) begin
            v = OUT_MIN;
        end
        return v[OUT_W-1:0];
    endfunction

endpackage

// ----- hdl/angle_axis_rotation_matrix_top.sv -----
// Registers from input request to o_m_axis_tvalid: stage A, fold, CORDIC steps, sin/cos, products, Q48 sums, output.
// Throughput: one request per cycle unless stalled; each micro-rotation has its own register
// stage, each multiply its own multiplier: nothing in the datapath is shared between requests.
// Backpressure freezes the whole pipeline only once the output skid register is full.
// Reset (synchronous, active low) clears the valid bits; datapath registers are not reset.
`timescale 1ns / 1ps
module angle_axis_rotation_matrix_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // theta, axis_x, axis_y, axis_z (16 bits each, from bit 0 up)
    input  logic [aarm_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // r00, r01, r02, r10, r11, r12, r20, r21, r22 (18 bits each, from bit 0 up), zero pad
    output logic [aarm_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);
    import aarm_pkg::*;

    logic                  w_en;
    logic [VLD_LAST:0]     r_vld;

    // stage A: wrap and axis products
    t_wrap                 w_raw;
    t_ang                  n_a_ang;
    t_ang                  r_a_ang;
    t_axis                 w_ax, w_ay, w_az;
    t_axis                 r_a_ax, r_a_ay, r_a_az;
    t_uu                   r_a_sx, r_a_sy, r_a_sz;
    t_uu                   r_a_pxy, r_a_pxz, r_a_pyz;

    // stage B and CORDIC steps
    t_rot                  n_b_rot;
    t_geo                  n_b_geo;
    t_rot                  r_rot [0:N_STEPS];
    t_geo                  r_geo [0:N_STEPS];

    // post stages
    t_rot                  w_fin;
    t_ang                  w_s30, w_c30, w_s_rnd, w_oc_rnd;
    t_sc                   r_s20, r_oc20;
    t_geo                  r_p1_geo;
    t_sa                   r_sax, r_say, r_saz;
    t_ou                   r_ou0, r_ou1, r_ou2, r_ou01, r_ou02, r_ou12;
    t_acc                  w_sx14, w_sy14, w_sz14;
    t_acc                  r_acc [0:N_OUT-1];
    logic [OUT_PACK_W-1:0] w_res;

    logic                  r_out_vld;
    logic                  r_skid_vld;
    logic [OUT_PACK_W-1:0] r_out_data;
    logic [OUT_PACK_W-1:0] r_skid_data;

    // pipeline advances whenever the skid register is free
    assign w_en            = !r_skid_vld;
    assign o_s_axis_tready = w_en;

    assign w_ax = i_s_axis_tdata[2*IN_W-1:IN_W];
    assign w_ay = i_s_axis_tdata[3*IN_W-1:2*IN_W];
    assign w_az = i_s_axis_tdata[4*IN_W-1:3*IN_W];

    // Q3.12 -> Q2.30, wrap once into [-pi, pi]
    always_comb begin
        w_raw = t_wrap'(signed'(i_s_axis_tdata[IN_W-1:0])) <<< 18;
        if (w_raw > PI_W) begin
            n_a_ang = t_ang'(w_raw - TWO_PI_W);
        end else if (w_raw < -PI_W) begin
            n_a_ang = t_ang'(w_raw + TWO_PI_W);
        end else begin
            n_a_ang = t_ang'(w_raw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_ang <= n_a_ang;
            r_a_ax  <= w_ax;
            r_a_ay  <= w_ay;
            r_a_az  <= w_az;
            r_a_sx  <= t_uu'(w_ax) * t_uu'(w_ax);
            r_a_sy  <= t_uu'(w_ay) * t_uu'(w_ay);
            r_a_sz  <= t_uu'(w_az) * t_uu'(w_az);
            r_a_pxy <= t_uu'(w_ax) * t_uu'(w_ay);
            r_a_pxz <= t_uu'(w_ax) * t_uu'(w_az);
            r_a_pyz <= t_uu'(w_ay) * t_uu'(w_az);
        end
    end

    // fold into [-pi/2, pi/2], negate sin/cos at the end; diagonal of U*U
    always_comb begin
        n_b_rot.x    = GAIN_Q30;
        n_b_rot.y    = '0;
        n_b_rot.flip = 1'b0;
        n_b_rot.z    = r_a_ang;
        if (r_a_ang > HALF_PI) begin
            n_b_rot.z    = r_a_ang - PI_Q30;
            n_b_rot.flip = 1'b1;
        end else if (r_a_ang < -HALF_PI) begin
            n_b_rot.z    = r_a_ang + PI_Q30;
            n_b_rot.flip = 1'b1;
        end
        n_b_geo.ax  = r_a_ax;
        n_b_geo.ay  = r_a_ay;
        n_b_geo.az  = r_a_az;
        n_b_geo.d0  = t_uu'(-(33'(r_a_sy) + 33'(r_a_sz)));
        n_b_geo.d1  = t_uu'(-(33'(r_a_sx) + 33'(r_a_sz)));
        n_b_geo.d2  = t_uu'(-(33'(r_a_sx) + 33'(r_a_sy)));
        n_b_geo.o01 = r_a_pxy;
        n_b_geo.o02 = r_a_pxz;
        n_b_geo.o12 = r_a_pyz;
    end

    // one micro-rotation per register stage
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rot[0] <= n_b_rot;
            r_geo[0] <= n_b_geo;
            for (int k = 0; k < N_STEPS; k++) begin
                r_rot[k+1] <= cordic_step(r_rot[k], k);
                r_geo[k+1] <= r_geo[k];
            end
        end
    end

    // sin and 1 - cos to Q20, rounded
    always_comb begin
        w_fin    = r_rot[N_STEPS];
        w_s30    = w_fin.flip ? -w_fin.y : w_fin.y;
        w_c30    = w_fin.flip ? -w_fin.x : w_fin.x;
        w_s_rnd  = (w_s30 + SC_ROUND) >>> 10;
        w_oc_rnd = (ONE_Q30 - w_c30 + SC_ROUND) >>> 10;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s20    <= t_sc'(w_s_rnd);
            r_oc20   <= t_sc'(w_oc_rnd);
            r_p1_geo <= r_geo[N_STEPS];
            r_sax    <= t_sa'(r_s20) * t_sa'(r_p1_geo.ax);
            r_say    <= t_sa'(r_s20) * t_sa'(r_p1_geo.ay);
            r_saz    <= t_sa'(r_s20) * t_sa'(r_p1_geo.az);
            r_ou0    <= t_ou'(r_oc20) * t_ou'(r_p1_geo.d0);
            r_ou1    <= t_ou'(r_oc20) * t_ou'(r_p1_geo.d1);
            r_ou2    <= t_ou'(r_oc20) * t_ou'(r_p1_geo.d2);
            r_ou01   <= t_ou'(r_oc20) * t_ou'(r_p1_geo.o01);
            r_ou02   <= t_ou'(r_oc20) * t_ou'(r_p1_geo.o02);
            r_ou12   <= t_ou'(r_oc20) * t_ou'(r_p1_geo.o12);
        end
    end

    assign w_sx14 = t_acc'(r_sax) <<< 14;
    assign w_sy14 = t_acc'(r_say) <<< 14;
    assign w_sz14 = t_acc'(r_saz) <<< 14;

    // Q48 sums, rounding half already added
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_acc[0] <= ONE_Q48 + t_acc'(r_ou0) + OUT_HALF;
            r_acc[1] <= -w_sz14 + t_acc'(r_ou01) + OUT_HALF;
            r_acc[2] <= w_sy14 + t_acc'(r_ou02) + OUT_HALF;
            r_acc[3] <= w_sz14 + t_acc'(r_ou01) + OUT_HALF;
            r_acc[4] <= ONE_Q48 + t_acc'(r_ou1) + OUT_HALF;
            r_acc[5] <= -w_sx14 + t_acc'(r_ou12) + OUT_HALF;
            r_acc[6] <= -w_sy14 + t_acc'(r_ou02) + OUT_HALF;
            r_acc[7] <= w_sx14 + t_acc'(r_ou12) + OUT_HALF;
            r_acc[8] <= ONE_Q48 + t_acc'(r_ou2) + OUT_HALF;
        end
    end

    always_comb begin
        for (int e = 0; e < N_OUT; e++) begin
            w_res[e*OUT_W +: OUT_W] = sat_out(r_acc[e]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[VLD_LAST-1:0], i_s_axis_tvalid};
        end
    end

    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (i_m_axis_tready) begin
                r_skid_vld <= 1'b0;
            end
        end else if (r_vld[VLD_LAST]) begin
            if (r_out_vld && !i_m_axis_tready) begin
                r_skid_vld <= 1'b1;
            end
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (i_m_axis_tready) begin
                r_out_data <= r_skid_data;
            end
        end else if (r_vld[VLD_LAST]) begin
            if (r_out_vld && !i_m_axis_tready) begin
                r_skid_data <= w_res;
            end else begin
                r_out_data <= w_res;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W - OUT_PACK_W){1'b0}}, r_out_data};

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_vld[0])
        else $error("accepted request did not enter the pipeline");

    a_exit_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[VLD_LAST] && w_en) |=> r_out_vld)
        else $error("finished request lost at the output");

    a_skid_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(r_out_vld && !i_m_axis_tready))
        else $error("skid filled while output was free");

    a_skid_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid holds data ahead of an empty output register");

endmodule
